FILE: rtl/core/srmt_pkg.sv
package srmt_pkg;

  localparam int WINDOW = 64;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 32;

  localparam logic [2:0] CFG_SCALE     = 3'd0;
  localparam logic [2:0] CFG_RMS_THR   = 3'd1;
  localparam logic [2:0] CFG_RMS_PER   = 3'd2;
  localparam logic [2:0] CFG_MEAN_THR  = 3'd3;
  localparam logic [2:0] CFG_MEAN_PER  = 3'd4;

  localparam logic [31:0] MAX31 = 32'h7FFF_FFFF;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [0:0] {
    DIV_MSC,
    DIV_RSC
  } div_sel_t;

  typedef struct packed {
    logic [30:0]        scale;
    logic [30:0]        rms_thr;
    logic [15:0]        rms_per;
    logic signed [31:0] mean_thr;
    logic [15:0]        mean_per;
  } cfg_t;

  typedef struct packed {
    logic     clr_wr;
    logic     accept;
    logic     mem_acc;
    logic     sum_upd;
    logic     div_start;
    div_sel_t div_sel;
    logic     mean_div_ld;
    logic     mean_sc_ld;
    logic     sq_ld;
    logic     sqrt_step;
    logic     rms_sc_ld;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic sqrt_last;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/srmt_div.sv
module srmt_div import srmt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], ge};
        rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/core/srmt_dp.sv
module srmt_dp import srmt_pkg::*; #(
  parameter int FRAC        = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  cfg_t               cfg,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_mean_out,
  output logic [30:0]        out_rms_out,
  output logic [30:0]        out_rms_raw,
  output logic               out_rms_trip,
  output logic               out_mean_trip
);

  localparam int AW  = $clog2(WINDOW);
  localparam int LSW = SAMPLE_BITS + AW + 1;
  localparam int SQW = 2 * SAMPLE_BITS + AW;

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic [AW-1:0]                 wr_pos_r;
  logic [AW-1:0]                 drop_pos_r;
  logic [AW-1:0]                 clr_pos_r;
  logic [AW-1:0]                 mem_wa;
  logic signed [SAMPLE_BITS-1:0] mem_wd;
  logic signed [LSW-1:0]         lsum_r;
  logic [SQW-1:0]                sqsum_r;
  logic signed [2*SAMPLE_BITS-1:0] new_sq;
  logic signed [2*SAMPLE_BITS-1:0] old_sq;
  logic [31:0]                   in_ext;
  logic [LSW-1:0]                lsum_mag;
  logic [NUM_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;
  logic [DEN_W-1:0]              coef;
  logic                          div_done;
  logic [NUM_W-1:0]              quo;
  logic                          mean_neg_r;
  logic [31:0]                   mraw_mag_r;
  logic [31:0]                   msc_mag;
  logic signed [31:0]            mean_sc_r;
  logic [30:0]                   rms_sc_r;
  logic [NUM_W-1:0]              sqn_r;
  logic [NUM_W-1:0]              sq_res_r;
  logic [NUM_W-1:0]              sq_bit_r;
  logic [NUM_W-1:0]              sq_t;
  logic [NUM_W-1:0]              rr_sh;
  logic [30:0]                   rms_raw_c;
  logic [15:0]                   rms_cnt_r;
  logic [15:0]                   mean_cnt_r;
  logic                          rms_over;
  logic                          mean_over;
  logic [15:0]                   rms_cnt_nxt;
  logic [15:0]                   mean_cnt_nxt;
  logic                          out_valid_r;

  function automatic logic [31:0] sat_mag(input logic [NUM_W-1:0] q, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (q > NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : q[31:0];
    end else begin
      res = (q > NUM_W'(MAX31)) ? MAX31 : q[31:0];
    end
    return res;
  endfunction

  assign in_ext = {16'd0, in_sample};

  assign mem_wa = cmd.clr_wr ? clr_pos_r : wr_pos_r;
  assign mem_wd = cmd.clr_wr ? '0 : sample_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.mem_acc) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.mem_acc) begin
      old_r <= mem[drop_pos_r];
    end
  end

  assign new_sq = sample_r * sample_r;
  assign old_sq = old_r * old_r;

  assign lsum_mag = lsum_r[LSW-1] ? LSW'(-lsum_r) : LSW'(lsum_r);
  assign coef     = (cfg.scale == '0) ? DEN_W'(1) : {1'b0, cfg.scale};

  always_comb begin
    case (cmd.div_sel)
      DIV_MSC: begin
        div_num = NUM_W'(mraw_mag_r) << FRAC;
        div_den = coef;
      end
      DIV_RSC: begin
        div_num = NUM_W'(rms_raw_c) << FRAC;
        div_den = coef;
      end
      default: begin
        div_num = '0;
        div_den = DEN_W'(1);
      end
    endcase
  end

  srmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign msc_mag   = sat_mag(quo, mean_neg_r);
  assign sq_t      = sq_res_r + sq_bit_r;
  assign rr_sh     = sq_res_r << FRAC;
  assign rms_raw_c = (rr_sh > NUM_W'(MAX31)) ? MAX31[30:0] : rr_sh[30:0];

  assign rms_over     = rms_sc_r >= cfg.rms_thr;
  assign mean_over    = mean_sc_r >= cfg.mean_thr;
  assign rms_cnt_nxt  = !rms_over ? 16'd0 :
                        ((rms_cnt_r == CNT_MAX) ? rms_cnt_r : rms_cnt_r + 16'd1);
  assign mean_cnt_nxt = !mean_over ? 16'd0 :
                        ((mean_cnt_r == CNT_MAX) ? mean_cnt_r : mean_cnt_r + 16'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      drop_pos_r  <= AW'(1);
      clr_pos_r   <= '0;
      lsum_r      <= '0;
      sqsum_r     <= '0;
      rms_cnt_r   <= '0;
      mean_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_pos_r <= clr_pos_r + 1'b1;
      end
      if (cmd.sum_upd) begin
        lsum_r     <= lsum_r - LSW'(old_r) + LSW'(sample_r);
        sqsum_r    <= sqsum_r - SQW'($unsigned(old_sq)) + SQW'($unsigned(new_sq));
        wr_pos_r   <= (wr_pos_r == AW'(WINDOW - 1)) ? '0 : wr_pos_r + 1'b1;
        drop_pos_r <= (drop_pos_r == AW'(WINDOW - 1)) ? '0 : drop_pos_r + 1'b1;
      end
      if (cmd.out_ld) begin
        rms_cnt_r   <= rms_cnt_nxt;
        mean_cnt_r  <= mean_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_ext[SAMPLE_BITS-1:0];
    end
    if (cmd.mean_div_ld) begin
      mean_neg_r <= lsum_r[LSW-1];
      mraw_mag_r <= sat_mag(NUM_W'(lsum_mag >> AW) << FRAC, lsum_r[LSW-1]);
    end
    if (cmd.mean_sc_ld) begin
      mean_sc_r <= mean_neg_r ? (~msc_mag + 32'd1) : msc_mag;
    end
    if (cmd.sq_ld) begin
      sqn_r    <= NUM_W'(sqsum_r >> AW);
      sq_res_r <= '0;
      sq_bit_r <= NUM_W'(1) << (NUM_W - 2);
    end
    if (cmd.sqrt_step) begin
      if (sqn_r >= sq_t) begin
        sqn_r    <= sqn_r - sq_t;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.rms_sc_ld) begin
      rms_sc_r <= (quo > NUM_W'(MAX31)) ? MAX31[30:0] : quo[30:0];
    end
    if (cmd.out_ld) begin
      out_mean_out  <= mean_sc_r;
      out_rms_out   <= rms_sc_r;
      out_rms_raw   <= rms_raw_c;
      out_rms_trip  <= rms_over && (rms_cnt_nxt >= cfg.rms_per);
      out_mean_trip <= mean_over && (mean_cnt_nxt >= cfg.mean_per);
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.clr_last  = clr_pos_r == AW'(WINDOW - 1);
  assign stat.div_done  = div_done;
  assign stat.sqrt_last = sq_bit_r[0];
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

FILE: rtl/core/srmt_ctrl.sv
module srmt_ctrl import srmt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MEM,
    S_SUM,
    S_MDIV,
    S_MSC,
    S_MSC_W,
    S_SQ,
    S_SQRT,
    S_RSC,
    S_RSC_W,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.div_sel = DIV_MSC;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_MEM;
        end
      end
      S_MEM: begin
        cmd.mem_acc = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.sum_upd = 1'b1;
        state_nxt   = S_MDIV;
      end
      S_MDIV: begin
        cmd.mean_div_ld = 1'b1;
        state_nxt       = S_MSC;
      end
      S_MSC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MSC;
        state_nxt     = S_MSC_W;
      end
      S_MSC_W: begin
        if (stat.div_done) begin
          cmd.mean_sc_ld = 1'b1;
          state_nxt      = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_ld = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_nxt = S_RSC;
      end
      S_RSC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RSC;
        state_nxt     = S_RSC_W;
      end
      S_RSC_W: begin
        if (stat.div_done) begin
          cmd.rms_sc_ld = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

FILE: rtl/core/sliding_rms_mean_trip_detector.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | in_sample
// out     | output    | out_valid/out_stall | out_mean_out, out_rms_out, out_rms_raw, trips
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata
// Each sample passes through two divisions by the coefficient in one shared restoring divider,
// a 32-step square root and single control steps before its result is valid; the next sample
// is accepted only after that result has been loaded into the output register.
// After reset, all WINDOW entries of the sample memory are cleared while in_stall is high.
// A finished result waits in the output register; the next sample may start meanwhile,
// and its result waits until the output register is free.
module sliding_rms_mean_trip_detector import srmt_pkg::*; #(
  parameter int FRAC        = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_mean_out,
  output logic [30:0]        out_rms_out,
  output logic [30:0]        out_rms_raw,
  output logic               out_rms_trip,
  output logic               out_mean_trip,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale    <= 31'd65536;
      cfg_r.rms_thr  <= 31'h7FFF_FFFF;
      cfg_r.rms_per  <= 16'd1;
      cfg_r.mean_thr <= 32'sh7FFF_FFFF;
      cfg_r.mean_per <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:    cfg_r.scale    <= cfg_wdata[30:0];
        CFG_RMS_THR:  cfg_r.rms_thr  <= cfg_wdata[30:0];
        CFG_RMS_PER:  cfg_r.rms_per  <= cfg_wdata[15:0];
        CFG_MEAN_THR: cfg_r.mean_thr <= cfg_wdata;
        CFG_MEAN_PER: cfg_r.mean_per <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  srmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srmt_dp #(
    .FRAC        (FRAC),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg_r),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mean_out  (out_mean_out),
    .out_rms_out   (out_rms_out),
    .out_rms_raw   (out_rms_raw),
    .out_rms_trip  (out_rms_trip),
    .out_mean_trip (out_mean_trip)
  );

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during memory clear");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result transaction dropped");

endmodule

FILE: verif/sliding_rms_mean_trip_detector_tb.sv
module sliding_rms_mean_trip_detector_tb;
  import srmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 64;
  localparam int FRAC = 16;
  localparam logic [2:0] CFG_SPARE = 3'd5;
  localparam longint SAT_HI = 64'sh7FFF_FFFF;
  localparam longint SAT_LO = -64'sh8000_0000;

  typedef struct {
    logic signed [31:0] mean_val;
    logic [30:0]        rms_val;
    logic [30:0]        rms_unscaled;
    logic               rms_trip;
    logic               mean_trip;
  } trip_result_t;

  class trip_scoreboard;
    longint             window_mem[WIN];
    int                 wr_pos;
    int                 drop_pos;
    longint             lin_sum;
    longint unsigned    sq_sum;
    int                 rms_cnt;
    int                 mean_cnt;
    longint unsigned    scale;
    longint unsigned    rms_thr;
    longint unsigned    rms_per;
    longint             mean_thr;
    longint unsigned    mean_per;
    trip_result_t       expected_q[$];
    int                 errors;

    function new();
      foreach (window_mem[i]) window_mem[i] = 0;
      wr_pos = 0;
      drop_pos = 1;
      lin_sum = 0;
      sq_sum = 0;
      rms_cnt = 0;
      mean_cnt = 0;
      scale = 65536;
      rms_thr = 64'h7FFF_FFFF;
      rms_per = 1;
      mean_thr = 64'sh7FFF_FFFF;
      mean_per = 1;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_SCALE:    scale = data[30:0];
        CFG_RMS_THR:  rms_thr = data[30:0];
        CFG_RMS_PER:  rms_per = data[15:0];
        CFG_MEAN_THR: mean_thr = $signed(data);
        CFG_MEAN_PER: mean_per = data[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function longint clamp(longint v);
      return v < SAT_LO ? SAT_LO : (v > SAT_HI ? SAT_HI : v);
    endfunction

    function void note_sample(logic signed [15:0] smp);
      longint          sv;
      longint          old;
      longint          coef;
      longint          mean_raw;
      longint          mean_sc;
      longint unsigned raw;
      longint unsigned rsc;
      trip_result_t    r;
      sv = smp;
      window_mem[wr_pos] = sv;
      old = window_mem[drop_pos];
      lin_sum = lin_sum - old + sv;
      sq_sum = sq_sum - longint'(old * old) + longint'(sv * sv);
      coef = (scale == 0) ? 1 : longint'(scale);
      mean_raw = clamp((lin_sum / WIN) * (64'sd1 << FRAC));
      mean_sc = clamp((mean_raw * (64'sd1 << FRAC)) / coef);
      raw = int_sqrt(sq_sum / WIN) << FRAC;
      if (raw > 64'h7FFF_FFFF) raw = 64'h7FFF_FFFF;
      rsc = (raw << FRAC) / longint'(coef);
      if (rsc > 64'h7FFF_FFFF) rsc = 64'h7FFF_FFFF;
      if (rsc >= rms_thr) begin
        if (rms_cnt < 65535) rms_cnt++;
        r.rms_trip = (rms_cnt >= rms_per);
      end else begin
        rms_cnt = 0;
        r.rms_trip = 1'b0;
      end
      if (mean_sc >= mean_thr) begin
        if (mean_cnt < 65535) mean_cnt++;
        r.mean_trip = (mean_cnt >= mean_per);
      end else begin
        mean_cnt = 0;
        r.mean_trip = 1'b0;
      end
      r.mean_val = mean_sc[31:0];
      r.rms_val = rsc[30:0];
      r.rms_unscaled = raw[30:0];
      wr_pos = (wr_pos + 1 >= WIN) ? 0 : wr_pos + 1;
      drop_pos = (drop_pos + 1 >= WIN) ? 0 : drop_pos + 1;
      expected_q.push_back(r);
    endfunction

    function void check_result(trip_result_t act);
      trip_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction, mean %0d rms %0d", $realtime,
                 act.mean_val, act.rms_val);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.mean_val !== e.mean_val) begin
        $display("%0t: mean_out expected %0d actual %0d", $realtime, e.mean_val, act.mean_val);
        errors++;
      end
      if (act.rms_val !== e.rms_val) begin
        $display("%0t: rms_out expected %0d actual %0d", $realtime, e.rms_val, act.rms_val);
        errors++;
      end
      if (act.rms_unscaled !== e.rms_unscaled) begin
        $display("%0t: rms_raw expected %0d actual %0d", $realtime, e.rms_unscaled,
                 act.rms_unscaled);
        errors++;
      end
      if (act.rms_trip !== e.rms_trip) begin
        $display("%0t: rms_trip expected %0b actual %0b", $realtime, e.rms_trip, act.rms_trip);
        errors++;
      end
      if (act.mean_trip !== e.mean_trip) begin
        $display("%0t: mean_trip expected %0b actual %0b", $realtime, e.mean_trip,
                 act.mean_trip);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_mean_out;
  logic [30:0]        out_rms_out;
  logic [30:0]        out_rms_raw;
  logic               out_rms_trip;
  logic               out_mean_trip;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  trip_scoreboard     sb = new();
  bit                 no_idle = 0;
  int                 hold_requests = 0;
  int                 holds_done = 0;
  int                 hold_left = 0;
  logic signed [15:0] last_sample = '0;

  sliding_rms_mean_trip_detector u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mean_out(out_mean_out), .out_rms_out(out_rms_out), .out_rms_raw(out_rms_raw),
    .out_rms_trip(out_rms_trip), .out_mean_trip(out_mean_trip),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    trip_result_t act;
    if (out_valid && !out_stall) begin
      act.mean_val = out_mean_out;
      act.rms_val = out_rms_out;
      act.rms_unscaled = out_rms_raw;
      act.rms_trip = out_rms_trip;
      act.mean_trip = out_mean_trip;
      sb.check_result(act);
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done < hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= 2000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 15);
    end
  end

  task automatic send_sample(logic signed [15:0] smp);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    sb.note_sample(smp);
    last_sample = smp;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      4, 5: return $signed(16'($urandom_range(400))) - 16'sd200;
      6: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      7: return 16'($urandom_range(32767));
      8: return -16'sd1 - 16'($urandom_range(32767));
      9: return last_sample;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(int count);
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    run_random(10);
    wait_drained();

    write_reg(CFG_SCALE, 32'd1);
    write_reg(CFG_RMS_THR, 32'd0);
    write_reg(CFG_RMS_PER, 32'd0);
    write_reg(CFG_MEAN_THR, 32'h8000_0000);
    write_reg(CFG_MEAN_PER, 32'd0);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    repeat (70) send_sample(16'sh7FFF);
    run_random(30);
    wait_drained();

    write_reg(CFG_SCALE, 32'd65536);
    write_reg(CFG_RMS_THR, 32'd1_200_000_000);
    write_reg(CFG_RMS_PER, 32'd3);
    write_reg(CFG_MEAN_THR, 32'd0);
    write_reg(CFG_MEAN_PER, 32'd2);
    hold_requests = hold_requests + 1;
    run_random(75);
    no_idle = 1;
    run_random(75);
    no_idle = 0;
    wait_drained();

    write_reg(CFG_SCALE, 32'd0);
    write_reg(CFG_RMS_THR, 32'h7FFF_FFFF);
    write_reg(CFG_RMS_PER, 32'd65535);
    write_reg(CFG_MEAN_THR, 32'h7FFF_FFFF);
    write_reg(CFG_MEAN_PER, 32'd65535);
    run_random(60);
    wait_drained();

    write_reg(CFG_SCALE, 32'h7FFF_FFFF);
    write_reg(CFG_RMS_THR, 32'd1);
    write_reg(CFG_RMS_PER, 32'd1);
    write_reg(CFG_MEAN_THR, 32'hFFFF_FFFF);
    write_reg(CFG_MEAN_PER, 32'd1);
    run_random(100);
    wait_drained();

    repeat (3) begin
      write_reg(CFG_SCALE, $urandom_range(262144, 16384));
      write_reg(CFG_RMS_THR, $urandom_range(1_500_000_000, 100_000_000));
      write_reg(CFG_RMS_PER, $urandom_range(5, 1));
      write_reg(CFG_MEAN_THR, $urandom_range(400_000_000) - 200_000_000);
      write_reg(CFG_MEAN_PER, $urandom_range(5, 1));
      run_random(70);
      wait_drained();
    end

    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/srmt_pkg.sv
rtl/core/srmt_div.sv
rtl/core/srmt_dp.sv
rtl/core/srmt_ctrl.sv
rtl/core/sliding_rms_mean_trip_detector.sv
verif/sliding_rms_mean_trip_detector_tb.sv
